/* src/i2cmbe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package i2cmbe_pkg;

    // Reset value of the bus delay register.
    localparam logic [7:0] HPT_RESET = 8'd10;

    // Command codes carried in the opcode field.
    typedef enum logic [2:0] {
        OP_START  = 3'd0,
        OP_STOP   = 3'd1,
        OP_SEND   = 3'd2,
        OP_READ   = 3'd3,
        OP_WAITACK = 3'd4,
        OP_ACK    = 3'd5,
        OP_NACK   = 3'd6,
        OP_CHECK  = 3'd7
    } opcode_t;

    // Line level a step drives: low, released, unchanged, or the MSB of the send shift.
    typedef enum logic [1:0] {
        LV_LOW  = 2'd0,
        LV_HIGH = 2'd1,
        LV_KEEP = 2'd2,
        LV_TX   = 2'd3
    } level_t;

    // Side action of a step.
    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_SHIFT = 2'd1,
        ACT_RX    = 2'd2,
        ACT_ACK   = 2'd3
    } action_t;

    // Sequencer phases. Code 31 is unused and returns to idle.
    typedef enum logic [4:0] {
        PH_IDLE          = 5'd0,
        PH_STA_REL       = 5'd1,
        PH_STA_SDA_LO    = 5'd2,
        PH_STA_SCL_LO    = 5'd3,
        PH_STO_SCL_HI    = 5'd4,
        PH_STO_SDA_REL   = 5'd5,
        PH_TX_DATA       = 5'd6,
        PH_TX_SCL_HI     = 5'd7,
        PH_TX_SCL_LO     = 5'd8,
        PH_RX_SCL_HI     = 5'd9,
        PH_RX_SCL_LO     = 5'd10,
        PH_WA_REL        = 5'd11,
        PH_WA_SCL_HI     = 5'd12,
        PH_WA_SCL_LO     = 5'd13,
        PH_ACK_SDA_LO    = 5'd14,
        PH_ACK_SCL_HI    = 5'd15,
        PH_ACK_SCL_LO    = 5'd16,
        PH_ACK_REL       = 5'd17,
        PH_NAK_REL       = 5'd18,
        PH_NAK_SCL_HI    = 5'd19,
        PH_NAK_SCL_LO    = 5'd20,
        PH_CHK_STOP      = 5'd21,
        PH_CHK_START     = 5'd22,
        PH_CHK_SDA_LO    = 5'd23,
        PH_CHK_SCL_LO    = 5'd24,
        PH_CHK_TX_DATA   = 5'd25,
        PH_CHK_TX_SCL_HI = 5'd26,
        PH_CHK_TX_SCL_LO = 5'd27,
        PH_CHK_WA_REL    = 5'd28,
        PH_CHK_WA_SCL_HI = 5'd29,
        PH_CHK_WA_SCL_LO = 5'd30
    } phase_t;

    // One entry of the step table.
    typedef struct packed {
        level_t  scl;
        level_t  sda;
        action_t act;
        logic    hold;
        phase_t  nxt;
        phase_t  loop;
    } step_t;

    // First phase of each command.
    function automatic phase_t first_phase(input opcode_t op);
        phase_t p;
        unique case (op)
            OP_START:   p = PH_STA_REL;
            OP_STOP:    p = PH_STO_SCL_HI;
            OP_SEND:    p = PH_TX_DATA;
            OP_READ:    p = PH_RX_SCL_HI;
            OP_WAITACK: p = PH_WA_REL;
            OP_ACK:     p = PH_ACK_SDA_LO;
            OP_NACK:    p = PH_NAK_REL;
            OP_CHECK:   p = PH_CHK_STOP;
            default:    p = PH_IDLE;
        endcase
        return p;
    endfunction

    // Step table: line levels, action, whether a delay follows, next and loop phase.
    function automatic step_t step_decode(input phase_t p);
        step_t s;
        unique case (p)
            PH_IDLE:          s = '{LV_KEEP, LV_KEEP, ACT_NONE,  1'b0, PH_IDLE, PH_IDLE};
            PH_STA_REL:       s = '{LV_HIGH, LV_HIGH, ACT_NONE,  1'b1, PH_STA_SDA_LO, PH_IDLE};
            PH_STA_SDA_LO:    s = '{LV_KEEP, LV_LOW,  ACT_NONE,  1'b1, PH_STA_SCL_LO, PH_IDLE};
            PH_STA_SCL_LO:    s = '{LV_LOW,  LV_KEEP, ACT_NONE,  1'b1, PH_IDLE, PH_IDLE};
            PH_STO_SCL_HI:    s = '{LV_HIGH, LV_LOW,  ACT_NONE,  1'b1, PH_STO_SDA_REL, PH_IDLE};
            PH_STO_SDA_REL:   s = '{LV_KEEP, LV_HIGH, ACT_NONE,  1'b0, PH_IDLE, PH_IDLE};
            PH_TX_DATA:       s = '{LV_KEEP, LV_TX,   ACT_NONE,  1'b1, PH_TX_SCL_HI, PH_IDLE};
            PH_TX_SCL_HI:     s = '{LV_HIGH, LV_KEEP, ACT_NONE,  1'b1, PH_TX_SCL_LO, PH_IDLE};
            PH_TX_SCL_LO:     s = '{LV_LOW,  LV_KEEP, ACT_SHIFT, 1'b1, PH_IDLE, PH_TX_DATA};
            PH_RX_SCL_HI:     s = '{LV_HIGH, LV_KEEP, ACT_NONE,  1'b1, PH_RX_SCL_LO, PH_IDLE};
            PH_RX_SCL_LO:     s = '{LV_LOW,  LV_KEEP, ACT_RX,    1'b1, PH_IDLE, PH_RX_SCL_HI};
            PH_WA_REL:        s = '{LV_KEEP, LV_HIGH, ACT_NONE,  1'b1, PH_WA_SCL_HI, PH_IDLE};
            PH_WA_SCL_HI:     s = '{LV_HIGH, LV_KEEP, ACT_NONE,  1'b1, PH_WA_SCL_LO, PH_IDLE};
            PH_WA_SCL_LO:     s = '{LV_LOW,  LV_KEEP, ACT_ACK,   1'b1, PH_IDLE, PH_IDLE};
            PH_ACK_SDA_LO:    s = '{LV_KEEP, LV_LOW,  ACT_NONE,  1'b1, PH_ACK_SCL_HI, PH_IDLE};
            PH_ACK_SCL_HI:    s = '{LV_HIGH, LV_KEEP, ACT_NONE,  1'b1, PH_ACK_SCL_LO, PH_IDLE};
            PH_ACK_SCL_LO:    s = '{LV_LOW,  LV_KEEP, ACT_NONE,  1'b1, PH_ACK_REL, PH_IDLE};
            PH_ACK_REL:       s = '{LV_KEEP, LV_HIGH, ACT_NONE,  1'b0, PH_IDLE, PH_IDLE};
            PH_NAK_REL:       s = '{LV_KEEP, LV_HIGH, ACT_NONE,  1'b1, PH_NAK_SCL_HI, PH_IDLE};
            PH_NAK_SCL_HI:    s = '{LV_HIGH, LV_KEEP, ACT_NONE,  1'b1, PH_NAK_SCL_LO, PH_IDLE};
            PH_NAK_SCL_LO:    s = '{LV_LOW,  LV_KEEP, ACT_NONE,  1'b1, PH_IDLE, PH_IDLE};
            PH_CHK_STOP:      s = '{LV_HIGH, LV_LOW,  ACT_NONE,  1'b1, PH_CHK_START, PH_IDLE};
            PH_CHK_START:     s = '{LV_HIGH, LV_HIGH, ACT_NONE,  1'b1, PH_CHK_SDA_LO, PH_IDLE};
            PH_CHK_SDA_LO:    s = '{LV_KEEP, LV_LOW,  ACT_NONE,  1'b1, PH_CHK_SCL_LO, PH_IDLE};
            PH_CHK_SCL_LO:    s = '{LV_LOW,  LV_KEEP, ACT_NONE,  1'b1, PH_CHK_TX_DATA, PH_IDLE};
            PH_CHK_TX_DATA:   s = '{LV_KEEP, LV_TX,   ACT_NONE,  1'b1, PH_CHK_TX_SCL_HI, PH_IDLE};
            PH_CHK_TX_SCL_HI: s = '{LV_HIGH, LV_KEEP, ACT_NONE,  1'b1, PH_CHK_TX_SCL_LO, PH_IDLE};
            PH_CHK_TX_SCL_LO: s = '{LV_LOW,  LV_KEEP, ACT_SHIFT, 1'b1, PH_CHK_WA_REL,
                                    PH_CHK_TX_DATA};
            PH_CHK_WA_REL:    s = '{LV_KEEP, LV_HIGH, ACT_NONE,  1'b1, PH_CHK_WA_SCL_HI, PH_IDLE};
            PH_CHK_WA_SCL_HI: s = '{LV_HIGH, LV_KEEP, ACT_NONE,  1'b1, PH_CHK_WA_SCL_LO, PH_IDLE};
            PH_CHK_WA_SCL_LO: s = '{LV_LOW,  LV_KEEP, ACT_ACK,   1'b1, PH_STO_SCL_HI, PH_IDLE};
            default:          s = '{LV_KEEP, LV_KEEP, ACT_NONE,  1'b0, PH_IDLE, PH_IDLE};
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* src/i2c_master_bit_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bit-level open-drain I2C master, one bus tick per input item.
// Input channel (s_axis_*): each item is one tick. It carries cmd_valid, opcode,
// tx_byte and the SDA level sampled on that tick. A command is taken only while
// the engine is idle; cmd_valid is ignored while a sequence runs.
// Result channel (m_axis_*): exactly one item per input item, in order, with the
// SCL/SDA levels to drive, busy, a done pulse, the receive shift register and
// the last acknowledge bit (1 means NACK).
// Configuration: cfg_wen/cfg_wdata write the bus delay in ticks (0 acts as 1);
// write it only while the engine is idle.
// Output: each result is registered when its item is accepted.
// Throughput: one item per cycle unless stalled; the whole tick update is one
// step-table pass between the sequencer state registers and the result register.
// Stall: while a result waits on m_axis_tready, s_axis_tready follows it, so the
// result register is the only buffer and no item is lost or repeated.
// Reset: lines released, engine idle, delay 10 ticks, acknowledge bit 1.
module i2c_master_bit_engine
    import i2cmbe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wen,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [0] cmd_valid, [3:1] opcode, [11:4] tx_byte, [12] sda_in, [15:13] zero
    input  wire logic [15:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res,
    // [11:4] rx_byte, [12] ack_bit, [15:13] zero
    output logic [15:0]      m_axis_tdata
);

    // Input field split.
    logic       cmd_valid;
    opcode_t    opcode;
    logic [7:0] tx_byte;
    logic       sda_in;

    assign cmd_valid = s_axis_tdata[0];
    assign opcode    = opcode_t'(s_axis_tdata[3:1]);
    assign tx_byte   = s_axis_tdata[11:4];
    assign sda_in    = s_axis_tdata[12];

    // State registers.
    logic [7:0]  hpt_reg;
    phase_t      phase_reg, phase_next;
    logic [7:0]  delay_reg, delay_next;
    logic [2:0]  bit_idx_reg, bit_idx_next;
    logic [7:0]  tx_shift_reg, tx_shift_next;
    logic [7:0]  rx_shift_reg, rx_shift_next;
    logic        ack_reg, ack_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        done_next;
    logic        m_valid_reg;
    logic [15:0] m_data_reg;
    logic        s_accept;

    // A new item is taken whenever the result register is empty or being drained.
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Tick update: delay countdown or one step of the table.
    always_comb begin
        logic   was_busy;
        logic   run;
        logic   acted;
        phase_t cur;
        step_t  st;
        logic [7:0] dly;

        was_busy      = (phase_reg != PH_IDLE) || (delay_reg != 8'd0);
        run           = 1'b0;
        acted         = 1'b0;
        cur           = phase_reg;
        phase_next    = phase_reg;
        delay_next    = delay_reg;
        bit_idx_next  = bit_idx_reg;
        tx_shift_next = tx_shift_reg;
        rx_shift_next = rx_shift_reg;
        ack_next      = ack_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        dly           = (hpt_reg == 8'd0) ? 8'd1 : hpt_reg;

        priority if (!was_busy) begin
            if (cmd_valid) begin
                tx_shift_next = tx_byte;
                bit_idx_next  = 3'd0;
                if (opcode == OP_READ) begin
                    rx_shift_next = 8'd0;
                end
                cur   = first_phase(opcode);
                run   = 1'b1;
                acted = 1'b1;
            end
        end else if (delay_reg != 8'd0) begin
            delay_next = delay_reg - 8'd1;
            acted      = 1'b1;
        end else begin
            run   = 1'b1;
            acted = 1'b1;
        end

        st = step_decode(cur);
        if (run) begin
            unique case (st.act)
                ACT_RX:  rx_shift_next = {rx_shift_next[6:0], sda_in};
                ACT_ACK: ack_next = sda_in;
                default: ;
            endcase

            unique case (st.scl)
                LV_LOW:  scl_next = 1'b0;
                LV_HIGH: scl_next = 1'b1;
                default: ;
            endcase

            unique case (st.sda)
                LV_LOW:  sda_next = 1'b0;
                LV_HIGH: sda_next = 1'b1;
                LV_TX:   sda_next = tx_shift_next[7];
                default: ;
            endcase

            phase_next = st.nxt;
            if (st.act == ACT_SHIFT || st.act == ACT_RX) begin
                if (st.act == ACT_SHIFT) begin
                    if (bit_idx_next == 3'd7) begin
                        sda_next = 1'b1;
                    end
                    tx_shift_next = {tx_shift_next[6:0], 1'b0};
                end
                if (bit_idx_next == 3'd7) begin
                    bit_idx_next = 3'd0;
                end else begin
                    bit_idx_next = bit_idx_next + 3'd1;
                    phase_next   = st.loop;
                end
            end
            delay_next = st.hold ? (dly - 8'd1) : 8'd0;
        end

        done_next = acted && (phase_next == PH_IDLE) && (delay_next == 8'd0);
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hpt_reg <= HPT_RESET;
        end else if (cfg_wen) begin
            hpt_reg <= cfg_wdata;
        end
    end

    // Sequencer state advances once per accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            delay_reg    <= 8'd0;
            bit_idx_reg  <= 3'd0;
            tx_shift_reg <= 8'd0;
            rx_shift_reg <= 8'd0;
            ack_reg      <= 1'b1;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
        end else if (s_accept) begin
            phase_reg    <= phase_next;
            delay_reg    <= delay_next;
            bit_idx_reg  <= bit_idx_next;
            tx_shift_reg <= tx_shift_next;
            rx_shift_reg <= rx_shift_next;
            ack_reg      <= ack_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            m_valid_reg <= s_axis_tvalid;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= {3'b000, ack_next, rx_shift_next, done_next,
                           (phase_next != PH_IDLE) || (delay_next != 8'd0),
                           sda_next, scl_next};
        end
    end

    // A finishing tick never also reports busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tdata[3] && m_axis_tdata[2]))
        else $error("done and busy reported together");

    // An idle tick without a command leaves the engine idle and silent.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && phase_reg == PH_IDLE && delay_reg == 8'd0 && !cmd_valid)
        |=> (m_axis_tdata[2] == 1'b0 && m_axis_tdata[3] == 1'b0))
        else $error("idle tick without command changed busy or done");

    // While a delay counts down the phase does not move.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && delay_reg != 8'd0) |=> (phase_reg == $past(phase_reg)))
        else $error("phase advanced during a bus delay");

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import i2cmbe_pkg::*;

    // Result item as packed on m_axis_tdata, lowest bit last in the list.
    typedef struct packed {
        logic [2:0] pad;
        logic       ack;
        logic [7:0] rx;
        logic       done;
        logic       busy;
        logic       sda;
        logic       scl;
    } tick_out_t;

    // Input item as packed on s_axis_tdata.
    typedef struct packed {
        logic [2:0] pad;
        logic       sda;
        logic [7:0] txb;
        opcode_t    op;
        logic       cmd;
    } tick_in_t;

    // One row of the directed table; the outcome is only used when pinned is set.
    typedef struct packed {
        logic       wr_cfg;
        logic [7:0] cfg_val;
        logic       cmd;
        opcode_t    op;
        logic [7:0] txb;
        logic       sda;
        logic       pinned;
        tick_out_t  outcome;
    } dir_row_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_TICKS = 100;
    localparam int REPORT_LIMIT = 10;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [7:0]  cfg_wdata = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 16'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int bad_count = 0;
    int result_count = 0;
    int idle_cycles = 0;

    // Expected line and status items, oldest first.
    tick_out_t pending_lines [$];
    bit        pinned_armed = 1'b0;
    tick_out_t pinned_out;

    // Bus engine state as the testbench predicts it.
    logic [7:0] eng_hpt = HPT_RESET;
    phase_t     eng_phase = PH_IDLE;
    logic [7:0] eng_delay = 8'd0;
    logic [2:0] eng_bit = 3'd0;
    logic [7:0] eng_txsh = 8'd0;
    logic [7:0] eng_rxsh = 8'd0;
    logic       eng_ack = 1'b1;
    logic       eng_scl = 1'b1;
    logic       eng_sda = 1'b1;

    i2c_master_bit_engine dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic bit engine_busy();
        return (eng_phase != PH_IDLE) || (eng_delay != 8'd0);
    endfunction

    function automatic tick_in_t make_tick(input logic cmd, input opcode_t op,
                                           input logic [7:0] txb, input logic sda);
        tick_in_t t;
        t = '0;
        t.cmd = cmd;
        t.op  = op;
        t.txb = txb;
        t.sda = sda;
        return t;
    endfunction

    // One bus step: line changes, sampling and the move to the next phase.
    task automatic bus_step(input logic sda_bit);
        phase_t     nxt;
        logic       hold;
        logic       last_bit;
        logic [7:0] span;
        nxt = PH_IDLE;
        hold = 1'b1;
        last_bit = (eng_bit == 3'd7);
        span = (eng_hpt == 8'd0) ? 8'd1 : eng_hpt;
        case (eng_phase)
            PH_STA_REL: begin
                eng_scl = 1'b1;
                eng_sda = 1'b1;
                nxt = PH_STA_SDA_LO;
            end
            PH_STA_SDA_LO: begin
                eng_sda = 1'b0;
                nxt = PH_STA_SCL_LO;
            end
            PH_STA_SCL_LO: eng_scl = 1'b0;
            PH_STO_SCL_HI: begin
                eng_scl = 1'b1;
                eng_sda = 1'b0;
                nxt = PH_STO_SDA_REL;
            end
            PH_STO_SDA_REL, PH_ACK_REL: begin
                // Closing release finishes on the same tick, no delay after it.
                eng_sda = 1'b1;
                hold = 1'b0;
            end
            PH_TX_DATA: begin
                eng_sda = eng_txsh[7];
                nxt = PH_TX_SCL_HI;
            end
            PH_CHK_TX_DATA: begin
                eng_sda = eng_txsh[7];
                nxt = PH_CHK_TX_SCL_HI;
            end
            PH_TX_SCL_HI: begin
                eng_scl = 1'b1;
                nxt = PH_TX_SCL_LO;
            end
            PH_CHK_TX_SCL_HI: begin
                eng_scl = 1'b1;
                nxt = PH_CHK_TX_SCL_LO;
            end
            PH_TX_SCL_LO, PH_CHK_TX_SCL_LO: begin
                // After the eighth bit SDA is let go for the acknowledge.
                eng_scl = 1'b0;
                if (last_bit) begin
                    eng_sda = 1'b1;
                end
                eng_txsh = eng_txsh << 1;
                eng_bit = eng_bit + 3'd1;
                if (eng_phase == PH_TX_SCL_LO) begin
                    nxt = last_bit ? PH_IDLE : PH_TX_DATA;
                end else begin
                    nxt = last_bit ? PH_CHK_WA_REL : PH_CHK_TX_DATA;
                end
            end
            PH_RX_SCL_HI: begin
                eng_scl = 1'b1;
                nxt = PH_RX_SCL_LO;
            end
            PH_RX_SCL_LO: begin
                eng_rxsh = {eng_rxsh[6:0], sda_bit};
                eng_scl = 1'b0;
                eng_bit = eng_bit + 3'd1;
                nxt = last_bit ? PH_IDLE : PH_RX_SCL_HI;
            end
            PH_WA_REL: begin
                eng_sda = 1'b1;
                nxt = PH_WA_SCL_HI;
            end
            PH_WA_SCL_HI: begin
                eng_scl = 1'b1;
                nxt = PH_WA_SCL_LO;
            end
            PH_WA_SCL_LO: begin
                eng_ack = sda_bit;
                eng_scl = 1'b0;
            end
            PH_ACK_SDA_LO: begin
                eng_sda = 1'b0;
                nxt = PH_ACK_SCL_HI;
            end
            PH_ACK_SCL_HI: begin
                eng_scl = 1'b1;
                nxt = PH_ACK_SCL_LO;
            end
            PH_ACK_SCL_LO: begin
                eng_scl = 1'b0;
                nxt = PH_ACK_REL;
            end
            PH_NAK_REL: begin
                eng_sda = 1'b1;
                nxt = PH_NAK_SCL_HI;
            end
            PH_NAK_SCL_HI: begin
                eng_scl = 1'b1;
                nxt = PH_NAK_SCL_LO;
            end
            PH_NAK_SCL_LO: eng_scl = 1'b0;
            PH_CHK_STOP: begin
                eng_scl = 1'b1;
                eng_sda = 1'b0;
                nxt = PH_CHK_START;
            end
            PH_CHK_START: begin
                // Stop's SDA release and the restart's release share one step.
                eng_scl = 1'b1;
                eng_sda = 1'b1;
                nxt = PH_CHK_SDA_LO;
            end
            PH_CHK_SDA_LO: begin
                eng_sda = 1'b0;
                nxt = PH_CHK_SCL_LO;
            end
            PH_CHK_SCL_LO: begin
                eng_scl = 1'b0;
                nxt = PH_CHK_TX_DATA;
            end
            PH_CHK_WA_REL: begin
                eng_sda = 1'b1;
                nxt = PH_CHK_WA_SCL_HI;
            end
            PH_CHK_WA_SCL_HI: begin
                eng_scl = 1'b1;
                nxt = PH_CHK_WA_SCL_LO;
            end
            PH_CHK_WA_SCL_LO: begin
                eng_ack = sda_bit;
                eng_scl = 1'b0;
                nxt = PH_STO_SCL_HI;
            end
            default: hold = 1'b0;
        endcase
        eng_phase = nxt;
        eng_delay = hold ? span - 8'd1 : 8'd0;
    endtask

    // Predicts the result item of one accepted input item.
    task automatic predict_tick(input tick_in_t t, output tick_out_t r);
        bit acted;
        acted = 1'b0;
        if (!engine_busy()) begin
            if (t.cmd) begin
                eng_txsh = t.txb;
                eng_bit = 3'd0;
                if (t.op == OP_READ) begin
                    eng_rxsh = 8'd0;
                end
                case (t.op)
                    OP_START:   eng_phase = PH_STA_REL;
                    OP_STOP:    eng_phase = PH_STO_SCL_HI;
                    OP_SEND:    eng_phase = PH_TX_DATA;
                    OP_READ:    eng_phase = PH_RX_SCL_HI;
                    OP_WAITACK: eng_phase = PH_WA_REL;
                    OP_ACK:     eng_phase = PH_ACK_SDA_LO;
                    OP_NACK:    eng_phase = PH_NAK_REL;
                    default:    eng_phase = PH_CHK_STOP;
                endcase
                bus_step(t.sda);
                acted = 1'b1;
            end
        end else if (eng_delay != 8'd0) begin
            eng_delay = eng_delay - 8'd1;
            acted = 1'b1;
        end else begin
            bus_step(t.sda);
            acted = 1'b1;
        end
        r = '0;
        r.scl  = eng_scl;
        r.sda  = eng_sda;
        r.busy = engine_busy();
        r.done = acted && !engine_busy();
        r.rx   = eng_rxsh;
        r.ack  = eng_ack;
    endtask

    // Offers one item, with random sender gaps, and returns once it is taken.
    task automatic send_tick(input tick_in_t t);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= t;
        @(posedge aclk);
        while (!s_axis_tready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_lines.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Lets the running command finish, drains all results, then sets the delay.
    task automatic write_delay(input logic [7:0] v);
        while (engine_busy()) begin
            send_tick(make_tick(1'($urandom_range(1)), opcode_t'($urandom_range(7)),
                                8'($urandom_range(255)), 1'($urandom_range(1))));
        end
        hold_until_drained();
        cfg_wdata <= v;
        cfg_wen <= 1'b1;
        @(negedge aclk);
        cfg_wen <= 1'b0;
        eng_hpt = v;
    endtask

    // Receiver stalls.
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Result checking and prediction at each rising edge.
    always @(posedge aclk) begin
        tick_out_t got;
        tick_out_t want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                result_count++;
                if (pending_lines.size() == 0) begin
                    bad_count++;
                    if (bad_count <= REPORT_LIMIT) begin
                        $display("Result %0d arrived with nothing expected: %h",
                                 result_count, m_axis_tdata);
                    end
                end else begin
                    want = pending_lines.pop_front();
                    if (got.scl !== want.scl || got.sda !== want.sda ||
                        got.busy !== want.busy || got.done !== want.done ||
                        got.rx !== want.rx || got.ack !== want.ack) begin
                        bad_count++;
                        if (bad_count <= REPORT_LIMIT) begin
                            $display({"Result %0d differs (expected/actual): scl %b/%b ",
                                      "sda %b/%b busy %b/%b done %b/%b rx %h/%h ack %b/%b"},
                                     result_count, want.scl, got.scl, want.sda, got.sda,
                                     want.busy, got.busy, want.done, got.done,
                                     want.rx, got.rx, want.ack, got.ack);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_tick(s_axis_tdata, want);
                // A directed row may pin the item on which the engine goes idle.
                if (pinned_armed && !want.busy) begin
                    want = pinned_out;
                    pinned_armed = 1'b0;
                end
                pending_lines.push_back(want);
            end
        end
    end

    // Ends the run when nothing moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        dir_row_t   dir_rows [18];
        opcode_t    xfer_script [10];
        logic [7:0] hpt_plan [10];
        int         script_pos;
        opcode_t    op;
        tick_in_t   t;

        // Columns: wr_cfg, cfg_val, cmd, op, txb, sda, pinned,
        // outcome {pad, ack, rx, done, busy, sda, scl}.
        dir_rows = '{
            '{1'b0, 8'd0,   1'b0, OP_START,   8'h00, 1'b1, 1'b1,
              '{3'd0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
            '{1'b0, 8'd0,   1'b1, OP_START,   8'h00, 1'b1, 1'b1,
              '{3'd0, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0}},
            '{1'b1, 8'd1,   1'b1, OP_SEND,    8'hA5, 1'b0, 1'b1,
              '{3'd0, 1'b1, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0}},
            '{1'b0, 8'd0,   1'b1, OP_WAITACK, 8'h00, 1'b0, 1'b1,
              '{3'd0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0}},
            '{1'b0, 8'd0,   1'b1, OP_READ,    8'h00, 1'b1, 1'b1,
              '{3'd0, 1'b0, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b0}},
            '{1'b0, 8'd0,   1'b1, OP_ACK,     8'h00, 1'b1, 1'b1,
              '{3'd0, 1'b0, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b0}},
            '{1'b0, 8'd0,   1'b1, OP_READ,    8'hFF, 1'b0, 1'b1,
              '{3'd0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0}},
            '{1'b0, 8'd0,   1'b1, OP_NACK,    8'h00, 1'b0, 1'b1,
              '{3'd0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0}},
            '{1'b0, 8'd0,   1'b1, OP_WAITACK, 8'h00, 1'b1, 1'b1,
              '{3'd0, 1'b1, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0}},
            '{1'b0, 8'd0,   1'b1, OP_SEND,    8'h00, 1'b1, 1'b0, '0},
            '{1'b0, 8'd0,   1'b1, OP_SEND,    8'hFF, 1'b0, 1'b0, '0},
            '{1'b0, 8'd0,   1'b1, OP_STOP,    8'h00, 1'b0, 1'b1,
              '{3'd0, 1'b1, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1}},
            '{1'b0, 8'd0,   1'b1, OP_CHECK,   8'h42, 1'b0, 1'b0, '0},
            '{1'b1, 8'd0,   1'b1, OP_START,   8'h00, 1'b1, 1'b0, '0},
            '{1'b0, 8'd0,   1'b1, OP_CHECK,   8'hFF, 1'b1, 1'b0, '0},
            '{1'b1, 8'd255, 1'b1, OP_STOP,    8'h00, 1'b1, 1'b0, '0},
            '{1'b1, 8'd2,   1'b1, OP_READ,    8'h00, 1'b1, 1'b0, '0},
            '{1'b0, 8'd0,   1'b0, OP_CHECK,   8'hFF, 1'b0, 1'b0, '0}
        };
        // A typical transfer order keeps most random commands meaningful.
        xfer_script = '{OP_START, OP_CHECK, OP_START, OP_SEND, OP_WAITACK,
                        OP_READ, OP_ACK, OP_READ, OP_NACK, OP_STOP};
        hpt_plan = '{8'd1, 8'd2, 8'd0, HPT_RESET, 8'd3, 8'd1,
                     8'($urandom_range(1, 6)), 8'd2, 8'($urandom_range(1, 12)), 8'd4};
        script_pos = 0;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part: each row offers one item (a command where cmd is set), then filler
        // items until the engine is idle again; commands offered while busy are ignored.
        foreach (dir_rows[i]) begin
            if (dir_rows[i].wr_cfg) begin
                write_delay(dir_rows[i].cfg_val);
            end
            if (dir_rows[i].pinned) begin
                pinned_out = dir_rows[i].outcome;
                pinned_armed = 1'b1;
            end
            send_tick(make_tick(dir_rows[i].cmd, dir_rows[i].op, dir_rows[i].txb,
                                dir_rows[i].sda));
            while (engine_busy()) begin
                send_tick(make_tick(1'b1, opcode_t'($urandom_range(7)),
                                    8'($urandom_range(255)), dir_rows[i].sda));
            end
        end

        // Random part: one phase per delay setting, cycling through the idle modes.
        for (int p = 0; p < 10; p++) begin
            write_delay(hpt_plan[p]);
            case (p % 4)
                0: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct = 70;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 70;
                end
                default: begin
                    src_idle_pct = 17;
                    sink_stall_pct = 17;
                end
            endcase
            for (int n = 0; n < PHASE_TICKS; n++) begin
                if ($urandom_range(59) == 0) begin
                    hold_until_drained();
                end
                if (engine_busy()) begin
                    t = make_tick(1'($urandom_range(1)), opcode_t'($urandom_range(7)),
                                  8'($urandom_range(255)), 1'($urandom_range(1)));
                end else begin
                    if ($urandom_range(99) < 65) begin
                        op = xfer_script[script_pos];
                        script_pos = (script_pos + 1) % 10;
                    end else begin
                        op = opcode_t'($urandom_range(7));
                    end
                    t = make_tick($urandom_range(9) != 0, op, 8'($urandom_range(255)),
                                  1'($urandom_range(1)));
                end
                send_tick(t);
            end
        end

        hold_until_drained();
        repeat (5) @(negedge aclk);
        bad_count += pending_lines.size();
        if (bad_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
